/* hw/rtl/multi_rate_poll_scheduler_macros.svh */
// assertion macros shared by the poll scheduler modules
`ifndef MULTI_RATE_POLL_SCHEDULER_MACROS_SVH
`define MULTI_RATE_POLL_SCHEDULER_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define MRPS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("poll scheduler assertion failed");

// antecedent implies consequent in the next cycle
`define MRPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("poll scheduler assertion failed");

`else

`define MRPS_ASSERT_IMPL(lbl, ante, cons)
`define MRPS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* hw/rtl/mrps_pkg.sv */
// shared constants and controller/datapath interface types of the poll scheduler
package mrps_pkg;

  // default sizing
  localparam int SLOTS_DEF       = 16;
  localparam int PERIOD_BITS_DEF = 16;

  // item field widths
  localparam int FUNC_W      = 2;
  localparam int SLOT_W      = 4;
  localparam int PMS_W       = 16;
  localparam int BASE_W      = 16;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  // configuration port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] CFG_INIT_PERIOD = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_DISPATCH    = 1'b1;
  localparam logic [BASE_W-1:0]     INIT_PERIOD_RST = 16'd100;
  localparam logic                  DISPATCH_RST    = 1'b1;

  // item function codes
  localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REM  = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic add_wr;
    logic rem_clr;
    logic tick_inc;
    logic el_clr;
    logic idx_clr;
    logic idx_inc;
    logic g_load;
    logic g_start;
    logic g_take;
    logic g_commit;
    logic acc_wr;
    logic pend_set;
    logic out_push;
    logic out_final;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              slot_ok;
    logic              el_ge_base;
    logic              disp_en;
    logic              cur_valid;
    logic              idx_last;
    logic              fire;
    logic              pend_v;
    logic              out_free;
    logic              g_zero;
    logic              g_done;
  } dp_sts_t;

endpackage

/* hw/rtl/mrps_gcd.sv */
// iterative binary gcd unit, one reduction step per cycle
module mrps_gcd #(
  parameter int W = mrps_pkg::PERIOD_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] a_in,
  input  logic [W-1:0] b_in,
  output logic         done,
  output logic [W-1:0] result
);

  localparam int KW = $clog2(W) + 1;

  logic [W-1:0]  a_r, b_r;
  logic [KW-1:0] k_r;
  logic          run_r;

  // finished once either operand has gone to zero
  assign done   = run_r && ((a_r == '0) || (b_r == '0));
  assign result = (a_r | b_r) << k_r;

  // run flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else if (start) begin
      run_r <= 1'b1;
    end else if (done) begin
      run_r <= 1'b0;
    end
  end

  // reduction step: strip common twos, then odd difference halved
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a_in;
      b_r <= b_in;
      k_r <= '0;
    end else if (run_r && !done) begin
      priority if (!a_r[0] && !b_r[0]) begin
        a_r <= a_r >> 1;
        b_r <= b_r >> 1;
        k_r <= k_r + KW'(1);
      end else if (!a_r[0]) begin
        a_r <= a_r >> 1;
      end else if (!b_r[0]) begin
        b_r <= b_r >> 1;
      end else if (a_r >= b_r) begin
        a_r <= (a_r - b_r) >> 1;
      end else begin
        b_r <= (b_r - a_r) >> 1;
      end
    end
  end

endmodule

/* hw/rtl/mrps_dp.sv */
// datapath: slot stores, elapsed counter, gcd, pending fire and output register
`include "multi_rate_poll_scheduler_macros.svh"

module mrps_dp #(
  parameter int SLOTS       = mrps_pkg::SLOTS_DEF,
  parameter int PERIOD_BITS = mrps_pkg::PERIOD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mrps_pkg::dp_cmd_t                  cmd,
  output mrps_pkg::dp_sts_t                  sts,
  input  logic [mrps_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic [mrps_pkg::FUNC_W-1:0]        in_tuser,
  input  logic                               cfg_we,
  input  logic [mrps_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [mrps_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [mrps_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic [0:0]                         out_tuser,
  output logic                               out_tlast
);

  localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PB  = PERIOD_BITS;
  localparam int AW  = PB + 1;
  localparam int BW  = (PB > mrps_pkg::BASE_W) ? PB : mrps_pkg::BASE_W;
  localparam int CW  = (AW > BW) ? AW : BW;
  localparam int XW  = (SW > mrps_pkg::SLOT_W) ? SW : mrps_pkg::SLOT_W;
  localparam int PAD = mrps_pkg::OUT_TDATA_W - mrps_pkg::BASE_W - mrps_pkg::SLOT_W;

  // captured item
  logic [mrps_pkg::FUNC_W-1:0] item_func_r;
  logic [mrps_pkg::SLOT_W-1:0] item_slot_r;
  logic [mrps_pkg::PMS_W-1:0]  item_period_r;

  // configuration registers
  logic [mrps_pkg::BASE_W-1:0] init_period_r;
  logic                        disp_en_r;

  // slot state
  logic [SLOTS-1:0] valid_r;
  logic [PB-1:0]    period_mem [SLOTS];
  logic [AW-1:0]    accum_mem  [SLOTS];
  logic [PB-1:0]    per_rd_r;
  logic [AW-1:0]    acc_rd_r;
  logic [SW-1:0]    idx_r;

  // timing and gcd state
  logic [AW-1:0] elapsed_r, elapsed_nxt;
  logic [PB-1:0] gcd_r;
  logic          gcd_set_r;
  logic [PB-1:0] g_r;
  logic          g_done;
  logic [PB-1:0] g_result;

  // pending fire and output register
  logic                        pend_v_r;
  logic [SW-1:0]               pend_slot_r;
  logic                        out_valid_r;
  logic                        out_fired_r;
  logic [mrps_pkg::SLOT_W-1:0] out_slot_r;
  logic [mrps_pkg::BASE_W-1:0] out_base_r;
  logic                        out_last_r;

  // derived values
  logic [XW-1:0]  slot_x;
  logic [SW-1:0]  slot_idx;
  logic           slot_ok;
  logic [PB-1:0]  p_trunc, p_wr;
  logic [BW-1:0]  base_full, base_now;
  logic [AW:0]    acc_sum;
  logic [AW-1:0]  acc_sat, acc_nxt;
  logic           fire;
  logic           out_free;
  logic           acc_we;
  logic [SW-1:0]  acc_wa;
  logic [AW-1:0]  acc_wd;

  // item decode
  assign slot_x   = XW'(item_slot_r);
  assign slot_idx = slot_x[SW-1:0];
  assign slot_ok  = 32'(item_slot_r) < 32'(SLOTS);
  assign p_trunc  = PB'(item_period_r);
  assign p_wr     = (p_trunc == '0) ? PB'(1) : p_trunc;

  // effective base period, zero taken as one
  assign base_full = gcd_set_r ? BW'(gcd_r) : BW'(init_period_r);
  assign base_now  = (base_full == '0) ? BW'(1) : base_full;

  // accumulator update with saturation
  assign acc_sum = {1'b0, acc_rd_r} + {1'b0, elapsed_r};
  assign acc_sat = acc_sum[AW] ? '1 : acc_sum[AW-1:0];
  assign fire    = acc_sat >= AW'(per_rd_r);
  assign acc_nxt = fire ? '0 : acc_sat;

  assign out_free = !out_valid_r || out_tready;

  // status to controller
  assign sts.func       = item_func_r;
  assign sts.slot_ok    = slot_ok;
  assign sts.el_ge_base = CW'(elapsed_r) >= CW'(base_now);
  assign sts.disp_en    = disp_en_r;
  assign sts.cur_valid  = valid_r[idx_r];
  assign sts.idx_last   = idx_r == SW'(SLOTS - 1);
  assign sts.fire       = fire;
  assign sts.pend_v     = pend_v_r;
  assign sts.out_free   = out_free;
  assign sts.g_zero     = g_r == '0;
  assign sts.g_done     = g_done;

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_func_r   <= in_tuser;
      item_slot_r   <= in_tdata[mrps_pkg::SLOT_W-1:0];
      item_period_r <= in_tdata[mrps_pkg::SLOT_W +: mrps_pkg::PMS_W];
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_period_r <= mrps_pkg::INIT_PERIOD_RST;
      disp_en_r     <= mrps_pkg::DISPATCH_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        mrps_pkg::CFG_INIT_PERIOD: init_period_r <= cfg_wdata;
        mrps_pkg::CFG_DISPATCH:    disp_en_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.add_wr) begin
      valid_r[slot_idx] <= 1'b1;
    end else if (cmd.rem_clr) begin
      valid_r[slot_idx] <= 1'b0;
    end
  end

  // period store, read at the sweep index
  always_ff @(posedge clk) begin
    if (cmd.add_wr) begin
      period_mem[slot_idx] <= p_wr;
    end
    per_rd_r <= period_mem[idx_r];
  end

  // accumulator store: cleared on add, updated during expiry
  assign acc_we = cmd.add_wr || cmd.acc_wr;
  assign acc_wa = cmd.add_wr ? slot_idx : idx_r;
  assign acc_wd = cmd.add_wr ? '0 : acc_nxt;

  always_ff @(posedge clk) begin
    if (acc_we) begin
      accum_mem[acc_wa] <= acc_wd;
    end
    acc_rd_r <= accum_mem[idx_r];
  end

  // sweep index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + SW'(1);
    end
  end

  // elapsed counter, saturating
  always_comb begin
    elapsed_nxt = elapsed_r;
    if (cmd.el_clr) begin
      elapsed_nxt = '0;
    end else if (cmd.tick_inc && (elapsed_r != '1)) begin
      elapsed_nxt = elapsed_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
    end else begin
      elapsed_r <= elapsed_nxt;
    end
  end

  // gcd unit
  mrps_gcd #(
    .W (PB)
  ) u_gcd (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.g_start),
    .a_in   (g_r),
    .b_in   (per_rd_r),
    .done   (g_done),
    .result (g_result)
  );

  // running gcd over valid periods
  always_ff @(posedge clk) begin
    if (cmd.add_wr) begin
      g_r <= '0;
    end else if (cmd.g_load) begin
      g_r <= per_rd_r;
    end else if (cmd.g_take) begin
      g_r <= g_result;
    end
  end

  // committed base period
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gcd_r     <= '0;
      gcd_set_r <= 1'b0;
    end else if (cmd.g_commit) begin
      gcd_r     <= g_r;
      gcd_set_r <= 1'b1;
    end
  end

  // pending fire, held until the next fire or the end of the sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (cmd.pend_set) begin
      pend_v_r <= 1'b1;
    end else if (cmd.out_final) begin
      pend_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pend_set) begin
      pend_slot_r <= idx_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_push || cmd.out_final) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_push) begin
      out_fired_r <= 1'b1;
      out_slot_r  <= mrps_pkg::SLOT_W'(pend_slot_r);
      out_base_r  <= base_now[mrps_pkg::BASE_W-1:0];
      out_last_r  <= 1'b0;
    end else if (cmd.out_final) begin
      out_fired_r <= pend_v_r;
      out_slot_r  <= pend_v_r ? mrps_pkg::SLOT_W'(pend_slot_r) : '0;
      out_base_r  <= base_now[mrps_pkg::BASE_W-1:0];
      out_last_r  <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD{1'b0}}, out_base_r, out_slot_r};
  assign out_tuser  = out_fired_r;
  assign out_tlast  = out_last_r;

  // a committed base period is never zero
  `MRPS_ASSERT_IMPL(a_gcd_nonzero, gcd_set_r, gcd_r != '0)

endmodule

/* hw/rtl/mrps_ctrl.sv */
// controller state machine: item decode, gcd sweep and expiry sweep sequencing
`include "multi_rate_poll_scheduler_macros.svh"

module mrps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output mrps_pkg::dp_cmd_t cmd,
  input  mrps_pkg::dp_sts_t sts
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_DEC  = 11'b000_0000_0010,
    S_TCHK = 11'b000_0000_0100,
    S_GRD  = 11'b000_0000_1000,
    S_GLD  = 11'b000_0001_0000,
    S_GRUN = 11'b000_0010_0000,
    S_GCOM = 11'b000_0100_0000,
    S_XRD  = 11'b000_1000_0000,
    S_XEV  = 11'b001_0000_0000,
    S_FIN  = 11'b010_0000_0000,
    S_WAIT = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = state_r == S_IDLE;

  // next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        priority if ((sts.func == mrps_pkg::FUNC_ADD) && sts.slot_ok) begin
          cmd.add_wr  = 1'b1;
          cmd.idx_clr = 1'b1;
          state_nxt   = S_GRD;
        end else if ((sts.func == mrps_pkg::FUNC_REM) && sts.slot_ok) begin
          cmd.rem_clr = 1'b1;
          state_nxt   = S_FIN;
        end else if (sts.func == mrps_pkg::FUNC_TICK) begin
          cmd.tick_inc = 1'b1;
          state_nxt    = S_TCHK;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_TCHK: begin
        priority if (sts.el_ge_base && sts.disp_en) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_XRD;
        end else if (sts.el_ge_base) begin
          cmd.el_clr = 1'b1;
          state_nxt  = S_FIN;
        end else begin
          state_nxt = S_FIN;
        end
      end
      // gcd sweep: skip empty slots, fold each valid period into the running gcd
      S_GRD: begin
        priority if (sts.cur_valid) begin
          state_nxt = S_GLD;
        end else if (sts.idx_last) begin
          state_nxt = S_GCOM;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_GLD: begin
        if (sts.g_zero) begin
          cmd.g_load = 1'b1;
          if (sts.idx_last) begin
            state_nxt = S_GCOM;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_GRD;
          end
        end else begin
          cmd.g_start = 1'b1;
          state_nxt   = S_GRUN;
        end
      end
      S_GRUN: begin
        if (sts.g_done) begin
          cmd.g_take = 1'b1;
          if (sts.idx_last) begin
            state_nxt = S_GCOM;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_GRD;
          end
        end
      end
      S_GCOM: begin
        cmd.g_commit = 1'b1;
        state_nxt    = S_FIN;
      end
      // expiry sweep over valid slots
      S_XRD: begin
        priority if (sts.cur_valid) begin
          state_nxt = S_XEV;
        end else if (sts.idx_last) begin
          cmd.el_clr = 1'b1;
          state_nxt  = S_FIN;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_XEV: begin
        if (sts.fire && sts.pend_v && !sts.out_free) begin
          state_nxt = S_WAIT;
        end else begin
          cmd.acc_wr = 1'b1;
          if (sts.fire) begin
            cmd.pend_set = 1'b1;
            cmd.out_push = sts.pend_v;
          end
          if (sts.idx_last) begin
            cmd.el_clr = 1'b1;
            state_nxt  = S_FIN;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_XRD;
          end
        end
      end
      // output held by the sink: retry the evaluation once it drains
      S_WAIT: begin
        if (sts.out_free) begin
          state_nxt = S_XEV;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_final = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // results only go out when the output register can take them
  `MRPS_ASSERT_IMPL(a_push_when_free, (cmd.out_push || cmd.out_final), sts.out_free)
  // a held fire exists only while an expiry sweep or its close-out runs
  `MRPS_ASSERT_IMPL(a_pend_in_expiry, sts.pend_v, (state_r == S_XRD || state_r == S_XEV || state_r == S_WAIT || state_r == S_FIN))
  // every captured item is decoded next
  `MRPS_ASSERT_NEXT(a_capture_decodes, cmd.capture, state_r == S_DEC)

endmodule

/* hw/rtl/multi_rate_poll_scheduler.sv */
// top level of the multi-rate poll scheduler: controller and datapath
//
//  channel | direction | handshake             | payload
//  in_     | sink      | in_tvalid/in_tready   | in_tdata: slot, period_ms; in_tuser: func
//  out_    | source    | out_tvalid/out_tready | out_tdata, out_tuser, out_tlast
//  cfg_    | sink      | cfg_we                | cfg_addr, cfg_wdata
//
// one item at a time; an expiry pass steps through all SLOTS slots and evaluates
// each valid one. an add sweeps all slots and folds each valid period into the
// running gcd through the binary gcd unit.
// synchronous active-low reset clears valid bits and control; no clearing pass.
// a full output register stalls the close-out and any fire that meets a held one;
// the next item is taken while the last result still waits in the output register.
module multi_rate_poll_scheduler #(
  parameter int SLOTS       = mrps_pkg::SLOTS_DEF,
  parameter int PERIOD_BITS = mrps_pkg::PERIOD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // slot [3:0], period_ms [19:4], zero [23:20]
  input  logic [mrps_pkg::IN_TDATA_W-1:0]  in_tdata,
  // func [1:0]
  input  logic [mrps_pkg::FUNC_W-1:0]      in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // slot_out [3:0], base_period [19:4], zero [23:20]
  output logic [mrps_pkg::OUT_TDATA_W-1:0] out_tdata,
  // fired [0]
  output logic [0:0]                       out_tuser,
  output logic                             out_tlast,
  input  logic                             cfg_we,
  input  logic [mrps_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [mrps_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  mrps_pkg::dp_cmd_t cmd;
  mrps_pkg::dp_sts_t sts;

  // sequencing
  mrps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // slot stores, counters and output register
  mrps_dp #(
    .SLOTS       (SLOTS),
    .PERIOD_BITS (PERIOD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

/* tb/multi_rate_poll_scheduler_tb.sv */
// self-checking testbench for the multi-rate poll scheduler
module multi_rate_poll_scheduler_tb;
  import mrps_pkg::*;

  // spare function code, the block ignores it
  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
  localparam int unsigned ELAPSED_MAX = 17'h1FFFF;
  localparam int PHASES = 5;
  localparam int PHASE_ITEMS = 41;

  typedef struct packed {
    logic [PMS_W-1:0]  period_ms;
    logic [SLOT_W-1:0] slot;
    logic [FUNC_W-1:0] func;
  } poll_cmd_t;

  typedef struct packed {
    logic              fired;
    logic [SLOT_W-1:0] slot_out;
    logic [BASE_W-1:0] base_period;
    logic              is_last;
  } poll_report_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [FUNC_W-1:0]      in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [0:0]             out_tuser;
  logic                   out_tlast;
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // stimulus and expected reports
  poll_cmd_t    poll_cmds[$];
  poll_report_t reports_due[$];
  poll_cmd_t    cur_cmd;

  // shadow of the scheduler state
  int unsigned per_ms[SLOTS_DEF];
  int unsigned acc_ms[SLOTS_DEF];
  bit          live[SLOTS_DEF];
  int unsigned gcd_base = 0;
  bit          gcd_known = 1'b0;
  int unsigned elapsed_ms = 0;
  int unsigned init_ms = INIT_PERIOD_RST;
  bit          dispatch_on = DISPATCH_RST;

  bit          no_idle = 1'b0;
  int unsigned send_gap = 0;
  int unsigned hold = 0;
  int unsigned error_count = 0;
  int unsigned items_sent = 0;
  int unsigned reports_seen = 0;
  int unsigned fires_seen = 0;
  int unsigned expiries = 0;

  multi_rate_poll_scheduler DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // idle lengths: mostly short, now and then long
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned gcd_of(input int unsigned a, input int unsigned b);
    int unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // base period in force, zero read as one
  function automatic logic [BASE_W-1:0] effective_base();
    int unsigned b;
    b = gcd_known ? gcd_base : init_ms;
    return (b == 0) ? 1 : b[BASE_W-1:0];
  endfunction

  // update the shadow state for one item and queue the reports it causes
  task automatic advance_schedule(input poll_cmd_t c);
    poll_report_t rpt[$];
    poll_report_t r;
    int unsigned  p;
    int unsigned  g;
    int unsigned  sum;
    case (c.func)
      FUNC_ADD: begin
        p = (c.period_ms == 0) ? 1 : c.period_ms;
        per_ms[c.slot] = p;
        acc_ms[c.slot] = 0;
        live[c.slot] = 1'b1;
        g = 0;
        for (int i = 0; i < SLOTS_DEF; i++)
          if (live[i]) g = gcd_of(g, per_ms[i]);
        gcd_base = g & 16'hFFFF;
        gcd_known = 1'b1;
      end
      FUNC_REM: live[c.slot] = 1'b0;
      FUNC_TICK: begin
        if (elapsed_ms < ELAPSED_MAX) elapsed_ms++;
        if (elapsed_ms >= effective_base()) begin
          expiries++;
          if (dispatch_on) begin
            for (int i = 0; i < SLOTS_DEF; i++) begin
              if (live[i]) begin
                sum = acc_ms[i] + elapsed_ms;
                if (sum > ELAPSED_MAX) sum = ELAPSED_MAX;
                if (sum >= per_ms[i]) begin
                  acc_ms[i] = 0;
                  r.fired = 1'b1;
                  r.slot_out = i[SLOT_W-1:0];
                  r.base_period = effective_base();
                  r.is_last = 1'b0;
                  rpt = {rpt, r};
                end else begin
                  acc_ms[i] = sum;
                end
              end
            end
          end
          elapsed_ms = 0;
        end
      end
      default: ;
    endcase
    // anything that fires nothing still reports once
    if (rpt.size() == 0) begin
      r.fired = 1'b0;
      r.slot_out = '0;
      r.base_period = effective_base();
      r.is_last = 1'b0;
      rpt = {rpt, r};
    end
    rpt[rpt.size()-1].is_last = 1'b1;
    reports_due = {reports_due, rpt};
  endtask

  // item driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        advance_schedule(cur_cmd);
        items_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (poll_cmds.size() != 0) begin
          cur_cmd = poll_cmds.pop_front();
          in_tdata <= IN_TDATA_W'({cur_cmd.period_ms, cur_cmd.slot});
          in_tuser <= cur_cmd.func;
          in_tvalid <= 1'b1;
          send_gap = no_idle ? 0 : gap_len();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // report monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        reports_seen++;
        if (out_tuser[0]) fires_seen++;
        if (reports_due.size() == 0) begin
          $error("report with none expected: fired %0d slot_out %0d base_period %0d",
                 out_tuser[0], out_tdata[3:0], out_tdata[19:4]);
          error_count++;
        end else begin
          poll_report_t want;
          want = reports_due.pop_front();
          if (out_tuser[0] !== want.fired) begin
            $error("fired: expected %0d, got %0d", want.fired, out_tuser[0]);
            error_count++;
          end
          if (out_tdata[3:0] !== want.slot_out) begin
            $error("slot_out: expected %0d, got %0d", want.slot_out, out_tdata[3:0]);
            error_count++;
          end
          if (out_tdata[19:4] !== want.base_period) begin
            $error("base_period: expected %0d, got %0d", want.base_period,
                   out_tdata[19:4]);
            error_count++;
          end
          if (out_tlast !== want.is_last) begin
            $error("last: expected %0d, got %0d", want.is_last, out_tlast);
            error_count++;
          end
        end
      end
      if (hold != 0) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!no_idle && $urandom_range(0, 3) == 0) hold = gap_len();
      end
    end
  end

  task automatic queue_cmd(input logic [FUNC_W-1:0] f, input int unsigned s,
                           input int unsigned p);
    poll_cmd_t c;
    c.func = f;
    c.slot = s[SLOT_W-1:0];
    c.period_ms = p[PMS_W-1:0];
    poll_cmds = {poll_cmds, c};
  endtask

  // mostly ticks and small periods so that expiry passes come often
  function automatic poll_cmd_t random_cmd();
    poll_cmd_t   c;
    int unsigned r;
    int unsigned q;
    r = $urandom_range(0, 99);
    c.slot = SLOT_W'($urandom_range(0, SLOTS_DEF - 1));
    c.period_ms = PMS_W'($urandom);
    if (r < 55) begin
      c.func = FUNC_TICK;
    end else if (r < 77) begin
      c.func = FUNC_ADD;
      q = $urandom_range(0, 99);
      if (q < 80) c.period_ms = PMS_W'($urandom_range(1, 12));
      else if (q < 92) c.period_ms = PMS_W'($urandom_range(13, 300));
      else if (q < 95) c.period_ms = '0;
    end else if (r < 94) begin
      c.func = FUNC_REM;
    end else begin
      c.func = FUNC_SPARE;
    end
    return c;
  endfunction

  // wait until the block has nothing in hand
  task automatic wait_idle();
    do @(negedge clk);
    while (poll_cmds.size() != 0 || in_tvalid || reports_due.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    if (addr == CFG_INIT_PERIOD) init_ms = value;
    else dispatch_on = value[0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // stimulus sequence
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // before any add: idle tick, spare code, remove of an empty slot
    queue_cmd(FUNC_TICK, 0, 0);
    queue_cmd(FUNC_SPARE, 15, 16'hFFFF);
    queue_cmd(FUNC_REM, 9, 0);
    // zero initial period reads as one, so every tick expires
    write_reg(CFG_INIT_PERIOD, 16'd0);
    queue_cmd(FUNC_TICK, 0, 0);
    queue_cmd(FUNC_TICK, 0, 0);
    write_reg(CFG_INIT_PERIOD, 16'hFFFF);
    write_reg(CFG_DISPATCH, 16'd0);
    queue_cmd(FUNC_TICK, 0, 0);
    write_reg(CFG_INIT_PERIOD, 16'd2);
    write_reg(CFG_DISPATCH, 16'hFFFF);
    queue_cmd(FUNC_TICK, 0, 0);
    queue_cmd(FUNC_TICK, 0, 0);
    // zero period add, largest period, overwrite of a live slot
    queue_cmd(FUNC_ADD, 0, 0);
    queue_cmd(FUNC_TICK, 0, 0);
    queue_cmd(FUNC_ADD, 15, 16'hFFFF);
    queue_cmd(FUNC_TICK, 0, 0);
    queue_cmd(FUNC_ADD, 15, 2);
    queue_cmd(FUNC_ADD, 7, 3);
    queue_cmd(FUNC_TICK, 0, 0);
    queue_cmd(FUNC_TICK, 0, 0);
    queue_cmd(FUNC_TICK, 0, 0);
    // removal keeps the base period
    queue_cmd(FUNC_REM, 0, 0);
    queue_cmd(FUNC_TICK, 0, 0);
    queue_cmd(FUNC_REM, 0, 0);
    queue_cmd(FUNC_SPARE, 0, 0);
    queue_cmd(FUNC_ADD, 10, 16'hAAAA);
    queue_cmd(FUNC_TICK, 0, 0);

    // random phases under changing settings
    for (int ph = 0; ph < PHASES; ph++) begin
      write_reg(CFG_DISPATCH, {15'($urandom_range(0, 16'h7FFF)), (ph == 2) ? 1'b0 : 1'b1});
      write_reg(CFG_INIT_PERIOD, (ph == 4) ? 16'hFFFF : 16'($urandom_range(1, 16'hFFFF)));
      no_idle = (ph == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) poll_cmds = {poll_cmds, random_cmd()};
    end

    // drain, then let any stray report show
    do @(negedge clk);
    while (poll_cmds.size() != 0 || in_tvalid || reports_due.size() != 0);
    repeat (60) @(posedge clk);
    if (reports_due.size() != 0) begin
      $error("%0d reports never arrived", reports_due.size());
      error_count++;
    end
    $display("%0d items sent, %0d reports checked, %0d slot firings over %0d expiry passes",
             items_sent, reports_seen, fires_seen, expiries);
    if (error_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // watchdog
  initial begin
    #12_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

/* multi_rate_poll_scheduler.f */
+incdir+hw/rtl
hw/rtl/mrps_pkg.sv
hw/rtl/mrps_gcd.sv
hw/rtl/mrps_dp.sv
hw/rtl/mrps_ctrl.sv
hw/rtl/multi_rate_poll_scheduler.sv
tb/multi_rate_poll_scheduler_tb.sv
